/* design/fbq_pkg.sv */
`timescale 1ns / 1ps

package fbq_pkg;

	localparam int WIN_DEPTH = 64;
	localparam int WIN_AW    = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
	localparam int FT_W      = 24;
	localparam int SUM_W     = FT_W + WIN_AW;
	localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
	localparam int BUD_W     = 20;
	localparam int RUN_W     = 8;
	localparam int OVL_W     = 32;
	localparam int GPU_W     = 32;
	localparam int CFG_IW    = 3;

	localparam logic [GPU_W-1:0] TIMER_MAX_US = GPU_W'(1000000);

	localparam logic [CFG_IW-1:0] REG_TIMER_PRESENT = 3'd0;
	localparam logic [CFG_IW-1:0] REG_BUDGET        = 3'd1;
	localparam logic [CFG_IW-1:0] REG_LOOSE_BUDGET  = 3'd2;
	localparam logic [CFG_IW-1:0] REG_DEGRADE       = 3'd3;
	localparam logic [CFG_IW-1:0] REG_RECOVER       = 3'd4;

	localparam logic [1:0] LEVEL_HIGH = 2'd0;
	localparam logic [1:0] LEVEL_LOW  = 2'd2;

	typedef struct packed {
		logic [BUD_W-1:0] budget;
		logic [BUD_W-1:0] loose_budget;
		logic [RUN_W-1:0] degrade_frames;
		logic [RUN_W-1:0] recover_frames;
	} fbq_cfg_t;

	typedef struct packed {
		logic [1:0]       level;
		logic [OVL_W-1:0] overload;
	} fbq_status_t;

endpackage

/* design/fbq_ram.sv */
`timescale 1ns / 1ps

module fbq_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/fbq_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, most significant bit first.
module fbq_div
	import fbq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SUM_W-1:0]  dividend,
	input  logic [FILL_W-1:0] divisor,
	output logic              done,
	output logic [SUM_W-1:0]  quotient
);

	localparam int CNT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [FILL_W-1:0] den_q;
	logic [FILL_W-1:0] rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [FILL_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			// The remainder stays below the divisor, so its top bit drops off.
			rem_q <= fits ? FILL_W'(trial - {1'b0, den_q}) : trial[FILL_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* design/fbq_level.sv */
`timescale 1ns / 1ps

module fbq_level
	import fbq_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            upd,
	input  logic [FT_W-1:0] ft,
	input  fbq_cfg_t        cfg,
	output fbq_status_t     status
);

	logic [1:0]       level_q, level_n;
	logic [RUN_W-1:0] over_run_q, over_run_n;
	logic [RUN_W-1:0] good_run_q, good_run_n;
	logic [OVL_W-1:0] overload_q, overload_n;
	logic             over;

	assign over = ft > FT_W'(cfg.budget);

	always_comb begin
		level_n    = level_q;
		overload_n = overload_q;
		if (over) begin
			overload_n = (overload_q == '1) ? overload_q : overload_q + 1'b1;
			over_run_n = (over_run_q == '1) ? over_run_q : over_run_q + 1'b1;
			good_run_n = '0;
		end else begin
			over_run_n = '0;
			if (level_q != LEVEL_HIGH && ft < FT_W'(cfg.loose_budget)) begin
				good_run_n = (good_run_q == '1) ? good_run_q : good_run_q + 1'b1;
			end else begin
				good_run_n = '0;
			end
		end
		// The drop test runs first; the rise test then sees the new level.
		if (over_run_n >= cfg.degrade_frames && level_n < LEVEL_LOW) begin
			level_n    = level_n + 2'd1;
			over_run_n = '0;
			good_run_n = '0;
		end
		if (good_run_n >= cfg.recover_frames && level_n != LEVEL_HIGH) begin
			level_n    = level_n - 2'd1;
			good_run_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q    <= LEVEL_HIGH;
			over_run_q <= '0;
			good_run_q <= '0;
			overload_q <= '0;
		end else if (upd) begin
			level_q    <= level_n;
			over_run_q <= over_run_n;
			good_run_q <= good_run_n;
			overload_q <= overload_n;
		end
	end

	assign status.level    = level_q;
	assign status.overload = overload_q;

endmodule

/* design/frame_budget_quality_governor.sv */
`timescale 1ns / 1ps
// From an accepted input beat to out_valid a frame passes the window read (ST_READ),
// the bit-serial divider for the average (ST_DIV) and the output load (ST_DONE).
// A new frame is taken only after the previous result is loaded into the output
// register, also while that result still waits there. Reset (arst_n low) clears
// all counters, the level and the config registers to their defaults at once, but
// not the output data; the window RAM needs no clearing, a fill count masks it.
module frame_budget_quality_governor
	import fbq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [BUD_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [GPU_W-1:0]  gpu_time_us,
	input  logic [FT_W-1:0]   cpu_dt_us,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        quality_level,
	output logic              degraded,
	output logic [2:0]        scale_quarters,
	output logic [FT_W-1:0]   frame_time_us,
	output logic [FT_W-1:0]   rolling_avg_us,
	output logic [OVL_W-1:0]  overload_total
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]        state_q;
	logic              timer_present_q;
	fbq_cfg_t          cfg_q;
	logic [WIN_AW-1:0] ptr_q;
	logic [FILL_W-1:0] fill_q, fill_n;
	logic [SUM_W-1:0]  sum_q, sum_n;
	logic [FT_W-1:0]   ft_q, ft_sel;
	logic [FT_W-1:0]   old_ft, ram_rdata;
	logic              accept, rd_phase, load_out;
	logic              div_done;
	logic [SUM_W-1:0]  div_quo;
	fbq_status_t       status;
	logic              out_valid_q;
	logic [1:0]        level_q;
	logic [FT_W-1:0]   ft_out_q, avg_out_q;
	logic [OVL_W-1:0]  overload_out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_present_q      <= 1'b0;
			cfg_q.budget         <= BUD_W'(16667);
			cfg_q.loose_budget   <= BUD_W'(15000);
			cfg_q.degrade_frames <= RUN_W'(3);
			cfg_q.recover_frames <= RUN_W'(10);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TIMER_PRESENT: timer_present_q      <= cfg_data[0];
				REG_BUDGET:        cfg_q.budget         <= cfg_data;
				REG_LOOSE_BUDGET:  cfg_q.loose_budget   <= cfg_data;
				REG_DEGRADE:       cfg_q.degrade_frames <= cfg_data[RUN_W-1:0];
				REG_RECOVER:       cfg_q.recover_frames <= cfg_data[RUN_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign rd_phase = (state_q == ST_READ);
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	assign ft_sel = (timer_present_q && gpu_time_us != '0 && gpu_time_us <= TIMER_MAX_US)
		? gpu_time_us[FT_W-1:0] : cpu_dt_us;

	fbq_ram #(
		.WIDTH(FT_W),
		.DEPTH(WIN_DEPTH)
	) u_window (
		.clk  (clk),
		.we   (rd_phase),
		.waddr(ptr_q),
		.wdata(ft_q),
		.re   (accept),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	// Slots are written in order, so until the window is full the old value counts as zero.
	assign old_ft = (fill_q == FILL_W'(WIN_DEPTH)) ? ram_rdata : '0;
	assign sum_n  = sum_q - SUM_W'(old_ft) + SUM_W'(ft_q);
	assign fill_n = (fill_q == FILL_W'(WIN_DEPTH)) ? fill_q : fill_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q   <= '0;
			fill_q  <= '0;
			sum_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_READ;
				ST_READ: begin
					state_q <= ST_DIV;
					sum_q   <= sum_n;
					fill_q  <= fill_n;
					ptr_q   <= (ptr_q == WIN_AW'(WIN_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
				end
				ST_DIV:  if (div_done) state_q <= ST_DONE;
				ST_DONE: if (load_out) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ft_q <= ft_sel;
		end
	end

	fbq_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rd_phase),
		.dividend(sum_n),
		.divisor (fill_n),
		.done    (div_done),
		.quotient(div_quo)
	);

	fbq_level u_level (
		.clk   (clk),
		.arst_n(arst_n),
		.upd   (rd_phase),
		.ft    (ft_q),
		.cfg   (cfg_q),
		.status(status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			level_q        <= status.level;
			ft_out_q       <= ft_q;
			avg_out_q      <= div_quo[FT_W-1:0];
			overload_out_q <= status.overload;
		end
	end

	assign out_valid      = out_valid_q;
	assign quality_level  = level_q;
	assign degraded       = (level_q != LEVEL_HIGH);
	assign scale_quarters = 3'd4 - {1'b0, level_q};
	assign frame_time_us  = ft_out_q;
	assign rolling_avg_us = avg_out_q;
	assign overload_total = overload_out_q;

	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input accepted without entering the busy sequence");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide phase");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WIN_DEPTH))
		else $error("window fill count beyond depth");

	a_level_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> quality_level != 2'd3)
		else $error("illegal quality level on output");

endmodule

/* dv/fbq_governor_checker.sv */
`timescale 1ns / 1ps

module fbq_governor_checker
	import fbq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [BUD_W-1:0]  cfg_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [GPU_W-1:0]  gpu_time_us,
	input  logic [FT_W-1:0]   cpu_dt_us,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [1:0]        quality_level,
	input  logic              degraded,
	input  logic [2:0]        scale_quarters,
	input  logic [FT_W-1:0]   frame_time_us,
	input  logic [FT_W-1:0]   rolling_avg_us,
	input  logic [OVL_W-1:0]  overload_total,
	output int                errors,
	output int                outstanding
);

	typedef struct packed {
		logic [1:0]       level;
		logic             degraded;
		logic [2:0]       scale;
		logic [FT_W-1:0]  frame_time;
		logic [FT_W-1:0]  average;
		logic [OVL_W-1:0] overloads;
	} frame_result_t;

	// Register copies.
	logic             timer_on;
	logic [BUD_W-1:0] budget;
	logic [BUD_W-1:0] loose;
	logic [RUN_W-1:0] degrade_n;
	logic [RUN_W-1:0] recover_n;

	// Governor state.
	logic [FT_W-1:0]  window_mem [WIN_DEPTH];
	int               wr_slot;
	logic [63:0]      win_sum;
	logic [31:0]      frame_count;
	logic [OVL_W-1:0] overload_cnt;
	logic [RUN_W-1:0] over_streak;
	logic [RUN_W-1:0] good_streak;
	logic [1:0]       cur_level;

	frame_result_t expected_frames [$];
	int            fail_count = 0;

	task automatic advance_governor(input logic [GPU_W-1:0] gpu, input logic [FT_W-1:0] cpu,
			output frame_result_t res);
		logic [FT_W-1:0] ft;
		logic [63:0]     divisor;
		if (timer_on && gpu >= 1 && gpu <= TIMER_MAX_US)
			ft = gpu[FT_W-1:0];
		else
			ft = cpu;
		if (frame_count != '1)
			frame_count = frame_count + 1'b1;

		win_sum = win_sum - 64'(window_mem[wr_slot]) + 64'(ft);
		window_mem[wr_slot] = ft;
		wr_slot = (wr_slot == WIN_DEPTH - 1) ? 0 : wr_slot + 1;
		divisor = (frame_count < WIN_DEPTH) ? 64'(frame_count) : 64'(WIN_DEPTH);

		if (ft > budget) begin
			if (overload_cnt != '1)
				overload_cnt = overload_cnt + 1'b1;
			if (over_streak != '1)
				over_streak = over_streak + 1'b1;
			good_streak = '0;
		end else begin
			over_streak = '0;
			if (cur_level != LEVEL_HIGH && ft < loose) begin
				if (good_streak != '1)
					good_streak = good_streak + 1'b1;
			end else begin
				good_streak = '0;
			end
		end

		// The drop is tested first; the rise then sees the new level.
		if (over_streak >= degrade_n && cur_level < LEVEL_LOW) begin
			cur_level = cur_level + 2'd1;
			over_streak = '0;
			good_streak = '0;
		end
		if (good_streak >= recover_n && cur_level != LEVEL_HIGH) begin
			cur_level = cur_level - 2'd1;
			good_streak = '0;
		end

		res.level = cur_level;
		res.degraded = (cur_level != LEVEL_HIGH);
		res.scale = 3'd4 - {1'b0, cur_level};
		res.frame_time = ft;
		res.average = FT_W'(win_sum / divisor);
		res.overloads = overload_cnt;
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_result_t exp_res;
		frame_result_t new_res;
		if (!arst_n) begin
			timer_on <= 1'b0;
			budget <= BUD_W'(16667);
			loose <= BUD_W'(15000);
			degrade_n <= RUN_W'(3);
			recover_n <= RUN_W'(10);
			for (int i = 0; i < WIN_DEPTH; i++)
				window_mem[i] = '0;
			wr_slot = 0;
			win_sum = '0;
			frame_count = '0;
			overload_cnt = '0;
			over_streak = '0;
			good_streak = '0;
			cur_level = LEVEL_HIGH;
			expected_frames.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TIMER_PRESENT: timer_on <= cfg_data[0];
					REG_BUDGET:        budget <= cfg_data;
					REG_LOOSE_BUDGET:  loose <= cfg_data;
					REG_DEGRADE:       degrade_n <= cfg_data[RUN_W-1:0];
					REG_RECOVER:       recover_n <= cfg_data[RUN_W-1:0];
					default: ;
				endcase
			end

			if (out_valid && !out_stall) begin
				if (expected_frames.size() == 0) begin
					$error("result beat with no frame outstanding");
					fail_count++;
				end else begin
					exp_res = expected_frames[0];
					expected_frames.delete(0);
					check_field("quality_level", exp_res.level, quality_level);
					check_field("degraded", exp_res.degraded, degraded);
					check_field("scale_quarters", exp_res.scale, scale_quarters);
					check_field("frame_time_us", exp_res.frame_time, frame_time_us);
					check_field("rolling_avg_us", exp_res.average, rolling_avg_us);
					check_field("overload_total", exp_res.overloads, overload_total);
				end
			end

			if (in_valid && !in_stall) begin
				advance_governor(gpu_time_us, cpu_dt_us, new_res);
				expected_frames.insert(expected_frames.size(), new_res);
			end

			outstanding <= expected_frames.size();
			errors <= fail_count;
		end
	end

endmodule

/* dv/tb_frame_budget_quality_governor.sv */
`timescale 1ns / 1ps

module tb_frame_budget_quality_governor;
	import fbq_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int PHASE_ITEMS    = 108;

	localparam logic [CFG_IW-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [CFG_IW-1:0] REG_SPARE_LAST  = 3'd7;

	typedef enum int {RUN_OVER, RUN_GOOD, RUN_MID, RUN_NOISE} frame_mix_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [BUD_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic [GPU_W-1:0]  gpu_time_us = '0;
	logic [FT_W-1:0]   cpu_dt_us = '0;
	logic              out_stall = 1'b0;
	logic              cfg_ready;
	logic              in_stall;
	logic              out_valid;
	logic [1:0]        quality_level;
	logic              degraded;
	logic [2:0]        scale_quarters;
	logic [FT_W-1:0]   frame_time_us;
	logic [FT_W-1:0]   rolling_avg_us;
	logic [OVL_W-1:0]  overload_total;

	int errors;
	int outstanding;
	bit quiet = 1'b0;
	int idle_cycles = 0;
	int stall_hold = 0;

	// Shadow of the written registers, used only to aim frame times and run lengths at the thresholds.
	bit               timer_on_s = 1'b0;
	logic [BUD_W-1:0] budget_s = BUD_W'(16667);
	logic [BUD_W-1:0] loose_s = BUD_W'(15000);
	logic [RUN_W-1:0] degrade_s = RUN_W'(3);
	logic [RUN_W-1:0] recover_s = RUN_W'(10);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	frame_budget_quality_governor dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.gpu_time_us(gpu_time_us),
		.cpu_dt_us(cpu_dt_us),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.quality_level(quality_level),
		.degraded(degraded),
		.scale_quarters(scale_quarters),
		.frame_time_us(frame_time_us),
		.rolling_avg_us(rolling_avg_us),
		.overload_total(overload_total)
	);

	fbq_governor_checker governor_chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.gpu_time_us(gpu_time_us),
		.cpu_dt_us(cpu_dt_us),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.quality_level(quality_level),
		.degraded(degraded),
		.scale_quarters(scale_quarters),
		.frame_time_us(frame_time_us),
		.rolling_avg_us(rolling_avg_us),
		.overload_total(overload_total),
		.errors(errors),
		.outstanding(outstanding)
	);

	// Mostly short gaps, now and then a long one.
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	always @(posedge clk) begin
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else begin
			out_stall <= !quiet && ($urandom_range(0, 2) == 0);
			stall_hold <= quiet ? 0 : pick_idle();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic wait_idle();
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IW-1:0] idx, input logic [BUD_W-1:0] data);
		// The last frame beat has been taken; keep it from being taken again.
		in_valid <= 1'b0;
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TIMER_PRESENT: timer_on_s = data[0];
			REG_BUDGET:        budget_s = data;
			REG_LOOSE_BUDGET:  loose_s = data;
			REG_DEGRADE:       degrade_s = data[RUN_W-1:0];
			REG_RECOVER:       recover_s = data[RUN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_frame(input logic [GPU_W-1:0] gpu, input logic [FT_W-1:0] cpu);
		int gap;
		gap = quiet ? 0 : pick_idle();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		gpu_time_us <= gpu;
		cpu_dt_us <= cpu;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	function automatic logic [FT_W-1:0] aim_time(frame_mix_t mix);
		case (mix)
			RUN_OVER: begin
				if ($urandom_range(0, 7) == 0)
					return '1;
				if ($urandom_range(0, 1) == 0)
					return budget_s + $urandom_range(1, 50);
				return budget_s + $urandom_range(1, 200000);
			end
			RUN_GOOD: begin
				if (loose_s == 0)
					return '0;
				if ($urandom_range(0, 1) == 0)
					return $urandom_range((loose_s > 40) ? loose_s - 40 : 0, loose_s - 1);
				return $urandom_range(0, loose_s - 1);
			end
			RUN_MID: return $urandom_range(loose_s, budget_s);
			default: return $urandom;
		endcase
	endfunction

	// Outside noise runs, the chosen time reaches the block either as a valid timer
	// reading or as the fallback next to a reading that must be rejected.
	task automatic send_mixed(frame_mix_t mix);
		logic [FT_W-1:0]  aim;
		logic [GPU_W-1:0] gpu;
		logic [FT_W-1:0]  cpu;
		aim = aim_time(mix);
		if (mix == RUN_NOISE) begin
			gpu = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 1000001);
			cpu = $urandom;
		end else if (timer_on_s && aim >= 1 && aim <= TIMER_MAX_US
				&& $urandom_range(0, 3) != 0) begin
			gpu = aim;
			cpu = $urandom;
		end else begin
			cpu = aim;
			case ($urandom_range(0, 3))
				0: gpu = '0;
				1: gpu = TIMER_MAX_US + 1;
				2: gpu = '1;
				default: gpu = timer_on_s ? ($urandom | 32'h0100_0000)
					: $urandom_range(1, 1000000);
			endcase
		end
		send_frame(gpu, cpu);
	endtask

	task automatic run_phase(input int count);
		frame_mix_t mix;
		int left;
		int run_len;
		int thresh;
		int r;
		left = count;
		while (left > 0) begin
			r = $urandom_range(0, 19);
			mix = (r < 7) ? RUN_OVER : (r < 14) ? RUN_GOOD : (r < 16) ? RUN_MID : RUN_NOISE;
			thresh = (mix == RUN_OVER) ? degrade_s : recover_s;
			run_len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4)
				: $urandom_range(1, thresh + 2);
			if (run_len > left)
				run_len = left;
			repeat (run_len) send_mixed(mix);
			left -= run_len;
		end
	endtask

	function automatic logic [RUN_W-1:0] pick_threshold(input int typical);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return RUN_W'(1);
			2: return '1;
			default: return $urandom_range(1, typical);
		endcase
	endfunction

	task automatic random_config();
		logic [BUD_W-1:0] bud;
		logic [BUD_W-1:0] lo;
		logic [BUD_W-1:0] data;
		int r;
		set_reg(REG_TIMER_PRESENT, $urandom);
		r = $urandom_range(0, 4);
		bud = (r == 0) ? '0 : (r == 1) ? '1 : (r == 2) ? BUD_W'(1000000)
			: $urandom_range(1000, 40000);
		set_reg(REG_BUDGET, bud);
		r = $urandom_range(0, 4);
		lo = (r == 0) ? '0 : (r == 1) ? '1 : (r == 2) ? bud : $urandom_range(bud / 2, bud);
		set_reg(REG_LOOSE_BUDGET, lo);
		// Bits above the register width ride along and must be dropped.
		data = $urandom;
		data[RUN_W-1:0] = pick_threshold(8);
		set_reg(REG_DEGRADE, data);
		data = $urandom;
		data[RUN_W-1:0] = pick_threshold(20);
		set_reg(REG_RECOVER, data);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// With the timer off the fallback wins even against a valid reading.
		send_frame(32'd500, 24'd0);
		send_frame(32'hFFFF_FFFF, 24'hFF_FFFF);
		set_reg(REG_TIMER_PRESENT, 20'hA5A5B);
		send_frame(32'd0, 24'd20000);
		send_frame(TIMER_MAX_US + 1, 24'd30000);
		send_frame(TIMER_MAX_US, 24'd5);
		send_frame(32'd1, 24'hFF_FFFF);
		send_frame(32'd16667, 24'd0);
		send_frame(32'd15000, 24'd0);
		repeat (3) send_frame(32'd16668, 24'd0);
		repeat (2) send_frame(32'd900000, 24'd0);
		repeat (10) send_frame(32'd14999, 24'd0);

		// Zero thresholds: every frame drops and rises again.
		set_reg(REG_DEGRADE, 20'hFFF00);
		set_reg(REG_RECOVER, 20'h12300);
		send_frame(32'd20000, 24'd0);
		send_frame(32'd100, 24'd0);
		set_reg(REG_SPARE_FIRST, 20'hFFFFF);
		set_reg(REG_SPARE_LAST, 20'h00000);
		send_frame(32'd1, 24'd0);

		for (int p = 0; p < 10; p++) begin
			quiet <= (p == 3 || p == 7);
			random_config();
			run_phase(PHASE_ITEMS);
		end
		quiet <= 1'b0;

		// A long overload: the slowest drop, then the over run pinned at its ceiling.
		set_reg(REG_TIMER_PRESENT, 20'd0);
		set_reg(REG_BUDGET, 20'd0);
		set_reg(REG_LOOSE_BUDGET, 20'd0);
		set_reg(REG_DEGRADE, 20'd255);
		set_reg(REG_RECOVER, 20'd1);
		repeat (260) send_mixed(RUN_OVER);
		set_reg(REG_DEGRADE, 20'd1);
		repeat (280) send_mixed(RUN_OVER);

		in_valid <= 1'b0;
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
